>>> rtl/core/ilb_pkg.sv
package ilb_pkg;

	localparam int AccW  = 128;
	localparam int HalfW = 64;
	localparam int CharW = 8;
	localparam int LimW  = 8;
	localparam int DigW  = 4;

	localparam logic [CharW-1:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [CharW-1:0] CH_MINUS      = 8'h2D;
	localparam logic [CharW-1:0] CH_PLUS       = 8'h2B;
	localparam logic [CharW-1:0] CH_ZERO       = 8'h30;
	localparam logic [CharW-1:0] CH_ONE        = 8'h31;
	localparam logic [CharW-1:0] CH_SEVEN      = 8'h37;
	localparam logic [CharW-1:0] CH_NINE       = 8'h39;
	localparam logic [CharW-1:0] CH_UPPER_A    = 8'h41;
	localparam logic [CharW-1:0] CH_UPPER_F    = 8'h46;
	localparam logic [CharW-1:0] CH_LOWER_A    = 8'h61;
	localparam logic [CharW-1:0] CH_LOWER_F    = 8'h66;
	localparam logic [CharW-1:0] CH_LOWER_X    = 8'h78;
	localparam logic [CharW-1:0] CH_UPPER_X    = 8'h58;
	localparam logic [CharW-1:0] CH_LOWER_B    = 8'h62;
	localparam logic [CharW-1:0] CH_UPPER_B    = 8'h42;
	localparam logic [CharW-1:0] CH_LOWER_L    = 8'h6C;
	localparam logic [CharW-1:0] CH_UPPER_L    = 8'h4C;

	typedef enum logic [1:0] {
		MODE_OCT = 2'd0,
		MODE_HEX = 2'd1,
		MODE_BIN = 2'd2,
		MODE_DEC = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_DIGIT = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_START  = 3'b001,
		PH_SIGNED = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [AccW-1:0]  mag;
		logic             neg;
		status_t          status;
		logic [CharW-1:0] bad_char;
	} res_t;

endpackage

>>> rtl/core/ilb_scan.sv
module ilb_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [ilb_pkg::CharW-1:0] char_code,
	input  logic [1:0]                mode,
	input  logic [ilb_pkg::LimW-1:0]  binary_digit_limit,
	input  logic                      last_char,
	output ilb_pkg::res_t             res
);
	import ilb_pkg::*;

	logic [AccW-1:0]  acc_q, acc_n, shifted, sum;
	logic             neg_q, neg_n;
	phase_t           ph_q, ph_n;
	logic             zp_q, zp_n;
	mode_t            hmode_q, m;
	logic [LimW-1:0]  hlim_q, lim;
	logic [LimW-1:0]  dc_q, dc_n;
	status_t          ec_q, ec_n;
	logic [CharW-1:0] ech_q, ech_n;
	logic             dig_ok, body, take, prefix, is_suffix;
	logic [DigW-1:0]  dig;

	always_comb begin
		m   = (ph_q == PH_START) ? mode_t'(mode) : hmode_q;
		lim = (ph_q == PH_START) ? binary_digit_limit : hlim_q;

		dig_ok = 1'b0;
		dig    = char_code[DigW-1:0];
		case (m)
			MODE_OCT: dig_ok = (char_code >= CH_ZERO) && (char_code <= CH_SEVEN);
			MODE_BIN: dig_ok = (char_code == CH_ZERO) || (char_code == CH_ONE);
			MODE_DEC: dig_ok = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
			MODE_HEX: begin
				if ((char_code >= CH_ZERO) && (char_code <= CH_NINE)) begin
					dig_ok = 1'b1;
				end else if (((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_F)) ||
						((char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_F))) begin
					dig_ok = 1'b1;
					dig    = char_code[DigW-1:0] + DigW'(9);
				end
			end
			default: dig_ok = 1'b0;
		endcase

		case (m)
			MODE_OCT: shifted = acc_q << 3;
			MODE_HEX: shifted = acc_q << 4;
			MODE_BIN: shifted = acc_q << 1;
			default:  shifted = (acc_q << 3) + (acc_q << 1);
		endcase
		sum = shifted + AccW'(dig);

		prefix = ((m == MODE_HEX) && ((char_code == CH_LOWER_X) || (char_code == CH_UPPER_X))) ||
			((m == MODE_BIN) && ((char_code == CH_LOWER_B) || (char_code == CH_UPPER_B)));
		is_suffix = last_char && ((char_code == CH_LOWER_L) || (char_code == CH_UPPER_L));

		acc_n = acc_q;
		neg_n = neg_q;
		ph_n  = ph_q;
		zp_n  = zp_q;
		dc_n  = dc_q;
		ec_n  = ec_q;
		ech_n = ech_q;
		body  = 1'b0;

		if (ec_q == ST_OK) begin
			if ((ph_q == PH_START) && ((char_code == CH_MINUS) || (char_code == CH_PLUS))) begin
				neg_n = (char_code == CH_MINUS);
				ph_n  = PH_SIGNED;
			end else if (zp_q) begin
				// The held zero lands on a zero accumulator, so only the binary count moves.
				zp_n = 1'b0;
				ph_n = PH_BODY;
				if (!prefix) begin
					body = 1'b1;
					if (m == MODE_BIN) begin
						if (lim == '0) begin
							ec_n  = ST_TOO_LONG;
							ech_n = '0;
						end else begin
							dc_n = LimW'(1);
						end
					end
				end
			end else if (ph_q != PH_BODY) begin
				ph_n = PH_BODY;
				if (((m == MODE_HEX) || (m == MODE_BIN)) && (char_code == CH_ZERO) && !last_char) begin
					zp_n = 1'b1;
				end else begin
					body = 1'b1;
				end
			end else begin
				body = 1'b1;
			end
		end else if (ph_q == PH_START) begin
			ph_n = PH_BODY;
		end

		take = body && !is_suffix && (char_code != CH_UNDERSCORE) && (ec_n == ST_OK);
		if (take) begin
			if (!dig_ok) begin
				ec_n  = ST_BAD_DIGIT;
				ech_n = char_code;
			end else if ((m == MODE_BIN) && ({1'b0, dc_n} + 9'd1 > {1'b0, lim})) begin
				ec_n  = ST_TOO_LONG;
				ech_n = '0;
			end else begin
				acc_n = sum;
				if (m == MODE_BIN) begin
					dc_n = dc_n + LimW'(1);
				end
			end
		end

		res.mag      = (ec_n != ST_OK) ? '0 : acc_n;
		res.neg      = neg_n;
		res.status   = ec_n;
		res.bad_char = (ec_n == ST_BAD_DIGIT) ? ech_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			ph_q    <= PH_START;
			zp_q    <= 1'b0;
			hmode_q <= MODE_OCT;
			hlim_q  <= '0;
			dc_q    <= '0;
			ec_q    <= ST_OK;
			ech_q   <= '0;
		end else if (fire) begin
			hmode_q <= m;
			hlim_q  <= lim;
			if (last_char) begin
				acc_q <= '0;
				neg_q <= 1'b0;
				ph_q  <= PH_START;
				zp_q  <= 1'b0;
				dc_q  <= '0;
				ec_q  <= ST_OK;
				ech_q <= '0;
			end else begin
				acc_q <= acc_n;
				neg_q <= neg_n;
				ph_q  <= ph_n;
				zp_q  <= zp_n;
				dc_q  <= dc_n;
				ec_q  <= ec_n;
				ech_q <= ech_n;
			end
		end
	end

endmodule

>>> rtl/core/ilb_result.sv
module ilb_result (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  ilb_pkg::res_t             res_in,
	output logic                      free,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ilb_pkg::HalfW-1:0] value_low,
	output logic [ilb_pkg::HalfW-1:0] value_high,
	output logic [1:0]                status,
	output logic [ilb_pkg::CharW-1:0] bad_char
);
	import ilb_pkg::*;

	res_t             res_s2;
	logic             v_s2;
	logic             move;
	logic [AccW-1:0]  signed_val;
	logic [AccW-1:0]  val_q;
	status_t          status_q;
	logic [CharW-1:0] bad_q;
	logic             ov_q;

	assign move       = v_s2 && (!ov_q || out_ready);
	assign free       = !v_s2 || move;
	assign signed_val = res_s2.neg ? (~res_s2.mag + AccW'(1)) : res_s2.mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (load) begin
				v_s2 <= 1'b1;
			end else if (move) begin
				v_s2 <= 1'b0;
			end
			if (move) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_in;
		end
		if (move) begin
			val_q    <= signed_val;
			status_q <= res_s2.status;
			bad_q    <= res_s2.bad_char;
		end
	end

	assign out_valid  = ov_q;
	assign value_low  = val_q[HalfW-1:0];
	assign value_high = val_q[AccW-1:HalfW];
	assign status     = status_q;
	assign bad_char   = bad_q;

endmodule

>>> rtl/core/integer_literal_to_binary_top.sv
// Results are registered in the result stage, then in the output register.
// Throughput: one character beat per cycle; a last beat waits on a free result stage.
// A beat's accumulator step: one 128-bit shift-and-add, input register to scan state.
// Reset clears all valid flags and the scan state; held mode and limit reset to zero.
module integer_literal_to_binary_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ilb_pkg::CharW-1:0] char_code,
	input  logic [1:0]                mode,
	input  logic [ilb_pkg::LimW-1:0]  binary_digit_limit,
	input  logic                      last_char,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ilb_pkg::HalfW-1:0] value_low,
	output logic [ilb_pkg::HalfW-1:0] value_high,
	output logic [1:0]                status,
	output logic [ilb_pkg::CharW-1:0] bad_char
);
	import ilb_pkg::*;

	logic             v_s1;
	logic [CharW-1:0] char_s1;
	logic [1:0]       mode_s1;
	logic [LimW-1:0]  lim_s1;
	logic             last_s1;
	logic             fire, s2_free;
	res_t             res;

	assign fire     = v_s1 && (!last_s1 || s2_free);
	assign in_ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			mode_s1 <= mode;
			lim_s1  <= binary_digit_limit;
			last_s1 <= last_char;
		end
	end

	ilb_scan u_scan (
		.clk                (clk),
		.arst_n             (arst_n),
		.fire               (fire),
		.char_code          (char_s1),
		.mode               (mode_s1),
		.binary_digit_limit (lim_s1),
		.last_char          (last_s1),
		.res                (res)
	);

	ilb_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire && last_s1),
		.res_in     (res),
		.free       (s2_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value_low  (value_low),
		.value_high (value_high),
		.status     (status),
		.bad_char   (bad_char)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (value_low == '0) && (value_high == '0))
		else $error("Error result carries a nonzero value.");

	a_bad_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_BAD_DIGIT) |-> (bad_char == '0))
		else $error("Offending character reported without a bad digit status.");

	a_stall_last: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && last_s1)
		else $error("Input stalled while not holding a final character.");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("Accepted beat was not captured in the input register.");

endmodule

>>> tb/integer_literal_to_binary_top_tb.sv
module integer_literal_to_binary_top_tb;
	import ilb_pkg::*;

	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic [CharW-1:0] ch;
		logic [1:0]       md;
		logic [LimW-1:0]  lim;
		logic             last;
	} char_beat_t;

	typedef struct packed {
		logic [HalfW-1:0] lo;
		logic [HalfW-1:0] hi;
		status_t          st;
		logic [CharW-1:0] bad;
	} literal_result_t;

	logic              clk;
	logic              arst_n             = 1'b0;
	logic              in_valid           = 1'b0;
	logic              in_ready;
	logic [CharW-1:0]  char_code          = '0;
	logic [1:0]        mode               = '0;
	logic [LimW-1:0]   binary_digit_limit = '0;
	logic              last_char          = 1'b0;
	logic              out_valid;
	logic              out_ready          = 1'b0;
	logic [HalfW-1:0]  value_low;
	logic [HalfW-1:0]  value_high;
	logic [1:0]        status;
	logic [CharW-1:0]  bad_char;

	char_beat_t        char_beats[$];
	literal_result_t   expected_values[$];
	logic [CharW-1:0]  lit_text[$];
	int                chars_queued   = 0;
	int                send_idle_pct  = 0;
	int                recv_stall_pct = 0;
	int                hold_left      = 0;
	logic              hold_req       = 1'b0;
	logic              beat_taken     = 1'b0;
	int                mismatches     = 0;

	logic [AccW-1:0]   run_value  = '0;
	logic              run_neg    = 1'b0;
	phase_t            run_phase  = PH_START;
	logic              zero_held  = 1'b0;
	mode_t             run_mode   = MODE_OCT;
	logic [LimW-1:0]   run_limit  = '0;
	logic [LimW-1:0]   bin_digits = '0;
	status_t           run_err    = ST_OK;
	logic [CharW-1:0]  run_bad    = '0;

	integer_literal_to_binary_top DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.char_code          (char_code),
		.mode               (mode),
		.binary_digit_limit (binary_digit_limit),
		.last_char          (last_char),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.value_low          (value_low),
		.value_high         (value_high),
		.status             (status),
		.bad_char           (bad_char)
	);

	function automatic void add_digit(logic [CharW-1:0] c);
		logic [3:0] d;
		logic       ok;
		if (run_err != ST_OK)
			return;
		d  = '0;
		ok = 1'b1;
		case (run_mode)
			MODE_OCT: begin
				if (c >= CH_ZERO && c <= CH_SEVEN) d = 4'(c - CH_ZERO);
				else ok = 1'b0;
			end
			MODE_HEX: begin
				if (c >= CH_ZERO && c <= CH_NINE) d = 4'(c - CH_ZERO);
				else if (c >= CH_UPPER_A && c <= CH_UPPER_F) d = 4'(c - CH_UPPER_A + 10);
				else if (c >= CH_LOWER_A && c <= CH_LOWER_F) d = 4'(c - CH_LOWER_A + 10);
				else ok = 1'b0;
			end
			MODE_BIN: begin
				if (c == CH_ZERO || c == CH_ONE) d = 4'(c - CH_ZERO);
				else ok = 1'b0;
			end
			default: begin
				if (c >= CH_ZERO && c <= CH_NINE) d = 4'(c - CH_ZERO);
				else ok = 1'b0;
			end
		endcase
		if (!ok) begin
			run_err = ST_BAD_DIGIT;
			run_bad = c;
			return;
		end
		if (run_mode == MODE_BIN) begin
			if ({1'b0, bin_digits} + 9'd1 > {1'b0, run_limit}) begin
				run_err = ST_TOO_LONG;
				run_bad = '0;
				return;
			end
			bin_digits = bin_digits + 1'b1;
		end
		case (run_mode)
			MODE_OCT: run_value = (run_value << 3) + d;
			MODE_HEX: run_value = (run_value << 4) + d;
			MODE_BIN: run_value = (run_value << 1) + d;
			default:  run_value = run_value * 128'd10 + d;
		endcase
	endfunction

	function automatic logic is_radix_prefix(logic [CharW-1:0] c);
		if (run_mode == MODE_HEX)
			return c == CH_LOWER_X || c == CH_UPPER_X;
		if (run_mode == MODE_BIN)
			return c == CH_LOWER_B || c == CH_UPPER_B;
		return 1'b0;
	endfunction

	function automatic void scan_char(char_beat_t b);
		logic            body;
		literal_result_t r;
		logic [AccW-1:0] v;
		body = 1'b0;
		if (run_phase == PH_START) begin
			run_mode  = mode_t'(b.md);
			run_limit = b.lim;
		end
		if (run_err == ST_OK) begin
			if (run_phase == PH_START && (b.ch == CH_MINUS || b.ch == CH_PLUS)) begin
				run_neg   = (b.ch == CH_MINUS);
				run_phase = PH_SIGNED;
			end else if (zero_held) begin
				zero_held = 1'b0;
				run_phase = PH_BODY;
				if (!is_radix_prefix(b.ch)) begin
					add_digit(CH_ZERO);
					body = 1'b1;
				end
			end else if (run_phase != PH_BODY) begin
				run_phase = PH_BODY;
				if ((run_mode == MODE_HEX || run_mode == MODE_BIN) && b.ch == CH_ZERO && !b.last)
					zero_held = 1'b1;
				else
					body = 1'b1;
			end else begin
				body = 1'b1;
			end
			if (body && !(b.last && (b.ch == CH_LOWER_L || b.ch == CH_UPPER_L))
					&& b.ch != CH_UNDERSCORE)
				add_digit(b.ch);
		end else if (run_phase == PH_START) begin
			run_phase = PH_BODY;
		end
		if (!b.last)
			return;
		if (run_err != ST_OK) v = '0;
		else if (run_neg) v = -run_value;
		else v = run_value;
		r.lo  = v[HalfW-1:0];
		r.hi  = v[AccW-1:HalfW];
		r.st  = run_err;
		r.bad = (run_err == ST_BAD_DIGIT) ? run_bad : '0;
		expected_values.push_back(r);
		run_value  = '0;
		run_neg    = 1'b0;
		run_phase  = PH_START;
		zero_held  = 1'b0;
		bin_digits = '0;
		run_err    = ST_OK;
		run_bad    = '0;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin : driver
		char_beat_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || beat_taken) begin
			beat_taken = 1'b0;
			if (char_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = char_beats.pop_front();
				char_code          <= nxt.ch;
				mode               <= nxt.md;
				binary_digit_limit <= nxt.lim;
				last_char          <= nxt.last;
				in_valid           <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		literal_result_t want;
		char_beat_t      got;
		if (arst_n && out_valid && out_ready) begin
			if (expected_values.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result beat: lo=%h hi=%h status=%0d bad=%h",
						value_low, value_high, status, bad_char);
			end else begin
				want = expected_values.pop_front();
				if (value_low !== want.lo || value_high !== want.hi
						|| status !== want.st || bad_char !== want.bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Mismatch: expected lo=%h hi=%h status=%0d bad=%h,",
							" got lo=%h hi=%h status=%0d bad=%h"},
							want.lo, want.hi, want.st, want.bad,
							value_low, value_high, status, bad_char);
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			got.ch   = char_code;
			got.md   = mode;
			got.lim  = binary_digit_limit;
			got.last = last_char;
			scan_char(got);
			beat_taken = 1'b1;
		end
	end

	task automatic load(input string s);
		lit_text.delete();
		for (int i = 0; i < s.len(); i++)
			lit_text.push_back(s[i]);
	endtask

	task automatic send_literal(input logic [1:0] md, input logic [LimW-1:0] lim);
		char_beat_t b;
		for (int i = 0; i < lit_text.size(); i++) begin
			b.ch   = lit_text[i];
			b.md   = (i == 0) ? md : 2'($urandom_range(3));
			b.lim  = (i == 0) ? lim : LimW'($urandom_range(255));
			b.last = (i == lit_text.size() - 1);
			char_beats.push_back(b);
			chars_queued++;
		end
	endtask

	task automatic make_random_literal();
		int               n;
		int               sgn;
		int               top;
		logic [1:0]       md;
		logic [LimW-1:0]  lim;
		logic [3:0]       d;
		lit_text.delete();
		md  = 2'($urandom_range(3));
		lim = LimW'($urandom_range(255));
		if ($urandom_range(99) < 12) begin
			n = $urandom_range(6, 1);
			for (int i = 0; i < n; i++)
				lit_text.push_back(CharW'($urandom_range(255)));
		end else begin
			sgn = $urandom_range(2);
			if (sgn == 1) lit_text.push_back(CH_PLUS);
			if (sgn == 2) lit_text.push_back(CH_MINUS);
			if ((md == MODE_HEX || md == MODE_BIN) && $urandom_range(1) == 1) begin
				lit_text.push_back(CH_ZERO);
				if (md == MODE_HEX)
					lit_text.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
				else
					lit_text.push_back($urandom_range(1) ? CH_LOWER_B : CH_UPPER_B);
			end
			top = $urandom_range(99);
			if (top < 8) n = 0;
			else if (top < 85) n = $urandom_range(10, 1);
			else n = $urandom_range(45, 11);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(9) == 0)
					lit_text.push_back(CH_UNDERSCORE);
				case (md)
					MODE_OCT: lit_text.push_back(CH_ZERO + CharW'($urandom_range(7)));
					MODE_BIN: lit_text.push_back(CH_ZERO + CharW'($urandom_range(1)));
					MODE_DEC: lit_text.push_back(CH_ZERO + CharW'($urandom_range(9)));
					default: begin
						d = 4'($urandom_range(15));
						if (d < 10)
							lit_text.push_back(CH_ZERO + d);
						else
							lit_text.push_back(($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A)
								+ d - 8'd10);
					end
				endcase
			end
			if ($urandom_range(3) == 0)
				lit_text.push_back($urandom_range(1) ? CH_LOWER_L : CH_UPPER_L);
			if (lit_text.size() == 0)
				lit_text.push_back(CH_ONE);
			if ($urandom_range(99) < 6)
				lit_text[$urandom_range(lit_text.size() - 1)] = CharW'($urandom_range(255));
			if (md == MODE_BIN) begin
				if ($urandom_range(9) == 0)
					lim = LimW'($urandom_range(n));
				else
					lim = LimW'($urandom_range(($urandom_range(7) == 0) ? 255 : 128, n));
			end
		end
		send_literal(md, lim);
	endtask

	task automatic drain();
		while (char_beats.size() != 0 || in_valid || expected_values.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic run_random(input int idle_pct, input int stall_pct, input int count);
		int target;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		target = chars_queued + count;
		while (chars_queued < target)
			make_random_literal();
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		load("-");      send_literal(MODE_DEC, 8'd0);
		load("+");      send_literal(MODE_OCT, 8'd0);
		load("0X");     send_literal(MODE_HEX, 8'd0);
		load("l");      send_literal(MODE_BIN, 8'd5);
		load("0g");     send_literal(MODE_HEX, 8'd0);
		load("7-");     send_literal(MODE_DEC, 8'd0);
		load("-F_fL");  send_literal(MODE_HEX, 8'd0);
		load("0b101");  send_literal(MODE_BIN, 8'd2);
		load("0b");     send_literal(MODE_BIN, 8'd0);
		load("-0");     send_literal(MODE_BIN, 8'd0);
		lit_text = '{8'hFF};
		send_literal(MODE_OCT, 8'd255);
		lit_text = '{8'h00};
		send_literal(MODE_DEC, 8'd128);
		drain();

		run_random(0, 0, 85);
		run_random(70, 0, 85);
		run_random(0, 70, 85);
		run_random(9, 9, 85);

		// The receiver holds off while the sender keeps offering, so the block backs up.
		hold_req = 1'b1;
		run_random(0, 0, 40);

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_values.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
